[rtl/rcnh_pkg.sv]
package rcnh_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_DX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_DY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_TEST,
        S_HM,
        S_HS,
        S_HW,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_TAKE,
        S_U0,
        S_U1,
        S_U2,
        S_U3,
        S_DX,
        S_DXW,
        S_DY,
        S_DYW,
        S_FIN
    } rcnh_state_t;

endpackage

[rtl/rcnh_sqrt.sv]
module rcnh_sqrt #(
    parameter int RW = 33
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root,
    output logic            done
);

    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*RW-1:0]  rad_reg;
    logic [RW:0]      rem_reg;
    logic [RW-1:0]    root_reg;

    logic [RW+2:0]    rem_t;
    logic [RW+2:0]    trial;
    logic [RW+2:0]    rem_d;
    logic             ge;

    // one result bit a cycle, two radicand bits shifted in
    always_comb
    begin
        rem_t = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
        trial = {1'b0, root_reg, 2'b01};
        ge    = rem_t >= trial;
        rem_d = rem_t - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (ge)
            begin
                rem_reg  <= rem_d[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[rtl/rcnh_fdiv.sv]
module rcnh_fdiv #(
    parameter int DW = 33,
    parameter int QB = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QB:0]   quot,
    output logic          done
);

    localparam int CNT_W = $clog2(QB + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    div_reg;
    logic [QB:0]      q_reg;

    logic [DW:0]      rem2;
    logic [DW:0]      rem2_d;
    logic             ge;

    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        ge     = rem2 >= {1'b0, div_reg};
        rem2_d = rem2 - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // integer bit first, then one fraction bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            if (dividend >= divisor)
            begin
                rem_reg <= dividend - divisor;
                q_reg   <= (QB+1)'(1);
            end
            else
            begin
                rem_reg <= dividend;
                q_reg   <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem2_d[DW-1:0] : rem2[DW-1:0];
            q_reg   <= {q_reg[QB-1:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

[rtl/ray_circle_nearest_hit.sv]
// Nearest circle hit along a 2D ray segment, fixed point Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS.
// Circles of one mesh stream in on s_axis; the circle with tlast set yields one result on
// m_axis (tuser = hit found) and clears the kept best for the next mesh. Everything runs on
// one registered multiplier, a bit-serial square root and a bit-serial fraction divider under
// a small sequencer, so one circle is in flight at a time and s_axis_tready stays low while it
// is worked on. The time a taken circle takes is set by the two square roots (one result bit per
// cycle) and the two normal divides (one quotient bit per cycle). A write of ray_dx or ray_dy
// recomputes the unit vector and length, during which cfg_ready and s_axis_tready are low.
// A finished result waits in the output register while the next circle is taken in.
module ray_circle_nearest_hit
    import rcnh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IN_W  = ((3 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + 2 * (FRAC_BITS + 2) + 7) / 8) * 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // center_x, center_y, circle_radius
    input  logic [IN_W-1:0]        s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // contact_x, contact_y, normal_x, normal_y, hit_distance
    output logic [OUT_W-1:0]       m_axis_tdata,
    // hit_found
    output logic                   m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int NW = FB + 2;
    localparam int MW = (CW + 1 > NW) ? CW + 1 : NW;
    localparam int P2 = 2 * MW;
    localparam int SW = CW + 2;

    localparam logic signed [SW-1:0] SMAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {3'b111, {(CW-1){1'b0}}};
    localparam logic [MW-1:0] CMAX_M = {{(MW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FB);
    localparam logic signed [NW-1:0] ONE_N = {2'b01, {FB{1'b0}}};

    function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
        if (v > SMAX)
            sat_c = SMAX[CW-1:0];
        else if (v < SMIN)
            sat_c = SMIN[CW-1:0];
        else
            sat_c = v[CW-1:0];
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
        mag_of = v[MW-1] ? -v : v;
    endfunction

    rcnh_state_t state_reg, state_next;

    // configuration and kept state
    logic signed [CW-1:0] origin_x_reg, origin_y_reg, ray_dx_reg, ray_dy_reg;
    logic                 keep_reg;
    logic [CW-2:0]        limit_reg;
    logic signed [CW-1:0] best_dist_reg, best_cx_reg, best_cy_reg;
    logic                 best_found_reg;
    logic signed [NW-1:0] best_nx_reg, best_ny_reg;
    logic signed [NW-1:0] unit_x_reg, unit_y_reg;
    logic signed [CW-1:0] ray_len_reg;
    logic                 dest_ray_reg;
    logic                 m_valid_reg;

    // output register
    logic                 out_hit_reg;
    logic signed [CW-1:0] out_cx_reg, out_cy_reg, out_dist_reg;
    logic signed [NW-1:0] out_nx_reg, out_ny_reg;

    // per-circle datapath
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [CW-2:0]        r_reg;
    logic                 last_reg;
    logic signed [CW-1:0] bx_reg, by_reg, acc_reg, proj_reg, perp_reg;
    logic signed [CW-1:0] hip_reg, px_reg, py_reg, kx_reg, ky_reg;
    logic [P2-1:0]        prod_reg, sq_reg;
    logic                 neg_reg;
    logic [MW-1:0]        ax_reg, ay_reg, len_reg;
    logic                 sx_reg, sy_reg;
    logic [FB:0]          qx_reg;

    logic                 in_fire, cfg_fire, ray_write, out_load;
    logic signed [CW-1:0] in_cx, in_cy, cfg_sdata;
    logic signed [MW-1:0] op_a, op_b;
    logic [MW-1:0]        raw_a, raw_b, mul_a, mul_b;
    logic                 raw, mul_neg;
    logic [P2-1:0]        mq_shift, mq_lim, mq_mag;
    logic signed [CW-1:0] mq;
    logic [CW-1:0]        perp_abs;
    logic signed [SW-1:0] r_s, ap_s, proj_s, bd_s, len_s, proj_hip, vdx, vdy;
    logic                 hit_test, behind;
    logic                 sqrt_start, sqrt_done, fd_start, fd_done;
    logic [P2-1:0]        sqrt_rad;
    logic [MW-1:0]        sqrt_root, fd_a;
    logic [FB:0]          fd_q;
    logic signed [NW-1:0] nx_val, ny_val;

    assign in_cx     = s_axis_tdata[CW-1:0];
    assign in_cy     = s_axis_tdata[2*CW-1:CW];
    assign cfg_sdata = cfg_data;

    assign cfg_ready     = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign ray_write     = cfg_fire && (cfg_index == CFG_RAY_DX || cfg_index == CFG_RAY_DY);

    // shared multiplier operand selection
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        raw   = 1'b0;
        raw_a = '0;
        raw_b = '0;
        case (state_reg)
            S_M0:
            begin
                op_a = MW'(bx_reg);
                op_b = MW'(unit_x_reg);
            end
            S_M1:
            begin
                op_a = MW'(by_reg);
                op_b = MW'(unit_y_reg);
            end
            S_M2:
            begin
                op_a = MW'(bx_reg);
                op_b = -MW'(unit_y_reg);
            end
            S_M3:
            begin
                op_a = MW'(by_reg);
                op_b = MW'(unit_x_reg);
            end
            S_HM:
            begin
                raw   = 1'b1;
                raw_a = MW'(r_reg) - MW'(perp_abs);
                raw_b = MW'(r_reg) + MW'(perp_abs);
            end
            S_P0:
            begin
                op_a = MW'(proj_reg);
                op_b = MW'(unit_x_reg);
            end
            S_P1:
            begin
                op_a = MW'(proj_reg);
                op_b = MW'(unit_y_reg);
            end
            S_P2:
            begin
                op_a = MW'(hip_reg);
                op_b = MW'(unit_x_reg);
            end
            S_P3:
            begin
                op_a = MW'(hip_reg);
                op_b = MW'(unit_y_reg);
            end
            S_U0:
            begin
                raw   = 1'b1;
                raw_a = ax_reg;
                raw_b = ax_reg;
            end
            S_U1:
            begin
                raw   = 1'b1;
                raw_a = ay_reg;
                raw_b = ay_reg;
            end
            default:
            begin
            end
        endcase
        mul_a   = raw ? raw_a : mag_of(op_a);
        mul_b   = raw ? raw_b : mag_of(op_b);
        mul_neg = op_a[MW-1] ^ op_b[MW-1];
    end

    // scaled product of the previous cycle: truncate magnitude, saturate, apply sign
    always_comb
    begin
        mq_shift = prod_reg >> FB;
        mq_lim   = {{(P2-CW){1'b0}}, neg_reg, {(CW-1){!neg_reg}}};
        mq_mag   = (mq_shift > mq_lim) ? mq_lim : mq_shift;
        mq       = neg_reg ? -$signed(mq_mag[CW-1:0]) : $signed(mq_mag[CW-1:0]);
    end

    always_comb
    begin
        perp_abs = perp_reg[CW-1] ? -perp_reg : perp_reg;
        r_s      = {3'b000, r_reg};
        ap_s     = {2'b00, perp_abs};
        proj_s   = SW'(proj_reg);
        bd_s     = SW'(best_dist_reg);
        len_s    = SW'(ray_len_reg);
        hit_test = !((proj_s - r_s) > bd_s) && (ap_s < r_s) && (proj_s >= -r_s)
                   && (proj_s <= len_s + r_s);
        proj_hip = proj_s - SW'(hip_reg);
        behind   = proj_hip[SW-1] || (proj_hip == '0);
        vdx      = SW'(kx_reg) - SW'(cx_reg);
        vdy      = SW'(ky_reg) - SW'(cy_reg);
        nx_val   = sx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
        ny_val   = sy_reg ? -$signed({1'b0, fd_q}) : $signed({1'b0, fd_q});
    end

    assign sqrt_start = (state_reg == S_HS) || (state_reg == S_U2);
    assign sqrt_rad   = (state_reg == S_U2) ? sq_reg + prod_reg : prod_reg;
    assign fd_start   = (state_reg == S_DX) || (state_reg == S_DY);
    assign fd_a       = (state_reg == S_DY) ? ay_reg : ax_reg;

    rcnh_sqrt #(
        .RW(MW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    rcnh_fdiv #(
        .DW(MW),
        .QB(FB)
    ) u_fdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fd_start),
        .dividend (fd_a),
        .divisor  (len_reg),
        .quot     (fd_q),
        .done     (fd_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (ray_write)
                    state_next = S_U0;
                else if (in_fire)
                    state_next = S_M0;
            end
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_TEST;
            S_TEST: state_next = hit_test ? S_HM : S_FIN;
            S_HM:   state_next = S_HS;
            S_HS:   state_next = S_HW;
            S_HW:
            begin
                if (sqrt_done)
                    state_next = S_P0;
            end
            S_P0:   state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = (behind && !keep_reg) ? S_FIN : S_TAKE;
            S_TAKE: state_next = S_U0;
            S_U0:   state_next = S_U1;
            S_U1:   state_next = S_U2;
            S_U2:   state_next = S_U3;
            S_U3:
            begin
                if (sqrt_done)
                begin
                    if (sqrt_root != '0)
                        state_next = S_DX;
                    else
                        state_next = dest_ray_reg ? S_IDLE : S_FIN;
                end
            end
            S_DX:   state_next = S_DXW;
            S_DXW:
            begin
                if (fd_done)
                    state_next = S_DY;
            end
            S_DY:   state_next = S_DYW;
            S_DYW:
            begin
                if (fd_done)
                    state_next = dest_ray_reg ? S_IDLE : S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            ray_dx_reg     <= ONE_C;
            ray_dy_reg     <= '0;
            keep_reg       <= 1'b0;
            limit_reg      <= '1;
            best_dist_reg  <= {1'b0, {(CW-1){1'b1}}};
            best_found_reg <= 1'b0;
            best_cx_reg    <= '0;
            best_cy_reg    <= '0;
            best_nx_reg    <= '0;
            best_ny_reg    <= '0;
            unit_x_reg     <= ONE_N;
            unit_y_reg     <= '0;
            ray_len_reg    <= ONE_C;
            dest_ray_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_sdata;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_sdata;
                    CFG_RAY_DX:
                    begin
                        ray_dx_reg   <= cfg_sdata;
                        dest_ray_reg <= 1'b1;
                    end
                    CFG_RAY_DY:
                    begin
                        ray_dy_reg   <= cfg_sdata;
                        dest_ray_reg <= 1'b1;
                    end
                    CFG_KEEP:     keep_reg <= cfg_data[0];
                    CFG_LIMIT:
                    begin
                        limit_reg     <= cfg_data[CW-2:0];
                        best_dist_reg <= {1'b0, cfg_data[CW-2:0]};
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_TAKE:
                begin
                    best_dist_reg  <= proj_reg;
                    best_found_reg <= 1'b1;
                    best_cx_reg    <= kx_reg;
                    best_cy_reg    <= ky_reg;
                    dest_ray_reg   <= 1'b0;
                end
                S_U3:
                begin
                    // zero-length vector gives a zero unit vector
                    if (sqrt_done && sqrt_root == '0)
                    begin
                        if (dest_ray_reg)
                        begin
                            unit_x_reg  <= '0;
                            unit_y_reg  <= '0;
                            ray_len_reg <= '0;
                        end
                        else
                        begin
                            best_nx_reg <= '0;
                            best_ny_reg <= '0;
                        end
                    end
                end
                S_DYW:
                begin
                    if (fd_done)
                    begin
                        if (dest_ray_reg)
                        begin
                            unit_x_reg  <= nx_val;
                            unit_y_reg  <= ny_val;
                            ray_len_reg <= (len_reg > CMAX_M) ? CMAX_M[CW-1:0]
                                                              : len_reg[CW-1:0];
                        end
                        else
                        begin
                            best_nx_reg <= nx_val;
                            best_ny_reg <= ny_val;
                        end
                    end
                end
                S_FIN:
                begin
                    // drop the kept best once the mesh result is loaded
                    if (out_load)
                    begin
                        best_dist_reg  <= {1'b0, limit_reg};
                        best_found_reg <= 1'b0;
                        best_cx_reg    <= '0;
                        best_cy_reg    <= '0;
                        best_nx_reg    <= '0;
                        best_ny_reg    <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= P2'(mul_a) * P2'(mul_b);
        neg_reg  <= mul_neg;

        if (in_fire)
        begin
            cx_reg   <= in_cx;
            cy_reg   <= in_cy;
            r_reg    <= s_axis_tdata[3*CW-2:2*CW];
            last_reg <= s_axis_tlast;
            bx_reg   <= sat_c(SW'(in_cx) - SW'(origin_x_reg));
            by_reg   <= sat_c(SW'(in_cy) - SW'(origin_y_reg));
        end

        if (cfg_fire && cfg_index == CFG_RAY_DX)
        begin
            ax_reg <= mag_of(MW'(cfg_sdata));
            sx_reg <= cfg_sdata[CW-1];
            ay_reg <= mag_of(MW'(ray_dy_reg));
            sy_reg <= ray_dy_reg[CW-1];
        end
        else if (cfg_fire && cfg_index == CFG_RAY_DY)
        begin
            ax_reg <= mag_of(MW'(ray_dx_reg));
            sx_reg <= ray_dx_reg[CW-1];
            ay_reg <= mag_of(MW'(cfg_sdata));
            sy_reg <= cfg_sdata[CW-1];
        end

        case (state_reg)
            S_M1: acc_reg  <= mq;
            S_M2: proj_reg <= sat_c(SW'(acc_reg) + SW'(mq));
            S_M3: acc_reg  <= mq;
            S_M4: perp_reg <= sat_c(SW'(acc_reg) + SW'(mq));
            S_HW:
            begin
                if (sqrt_done)
                    hip_reg <= sqrt_root[CW-1:0];
            end
            S_P1: px_reg <= sat_c(SW'(origin_x_reg) + SW'(mq));
            S_P2: py_reg <= sat_c(SW'(origin_y_reg) + SW'(mq));
            S_P3: kx_reg <= sat_c(SW'(px_reg) - SW'(mq));
            S_P4:
            begin
                // entry point at or behind the origin clamps to the origin
                if (behind)
                begin
                    kx_reg <= origin_x_reg;
                    ky_reg <= origin_y_reg;
                end
                else
                    ky_reg <= sat_c(SW'(py_reg) - SW'(mq));
            end
            S_TAKE:
            begin
                ax_reg <= mag_of(MW'(vdx));
                sx_reg <= vdx[SW-1];
                ay_reg <= mag_of(MW'(vdy));
                sy_reg <= vdy[SW-1];
            end
            S_U1: sq_reg <= prod_reg;
            S_U3:
            begin
                if (sqrt_done)
                    len_reg <= sqrt_root;
            end
            S_DXW:
            begin
                if (fd_done)
                    qx_reg <= fd_q;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_hit_reg  <= best_found_reg;
            out_cx_reg   <= best_found_reg ? best_cx_reg : '0;
            out_cy_reg   <= best_found_reg ? best_cy_reg : '0;
            out_nx_reg   <= best_found_reg ? best_nx_reg : '0;
            out_ny_reg   <= best_found_reg ? best_ny_reg : '0;
            out_dist_reg <= best_found_reg ? best_dist_reg : '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = OUT_W'({out_dist_reg, out_ny_reg, out_nx_reg,
                                   out_cy_reg, out_cx_reg});

endmodule
